FILE: rtl/core/binary32_float_adder_unit_defines.svh
// assertion macros shared by the adder rtl
`ifndef BINARY32_FLOAT_ADDER_UNIT_DEFINES_SVH
`define BINARY32_FLOAT_ADDER_UNIT_DEFINES_SVH
// a condition that must hold at every edge outside reset
`define FA_ASSERT_ALWAYS(label, clk_sig, rst_sig, cond, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) else $error(msg);
// an antecedent that implies a consequent in the next cycle
`define FA_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/fa_pkg.sv
// ----------------------------------------------------------------------------
// fa_pkg
// shared types and constants of the binary32 adder pipeline
// ----------------------------------------------------------------------------
package fa_pkg;

  localparam logic [31:0] QNAN_BITS    = 32'h7FFF_FFFF;
  localparam logic [31:0] IMPLICIT_ONE = 32'h4000_0000;
  localparam logic [22:0] FRAC_MASK    = 23'h7F_FFFF;
  localparam logic [7:0]  EXP_MASK     = 8'hFF;
  localparam logic [7:0]  EXP_MAX_NORM = 8'hFE;

  // stage 1 -> stage 2: aligned operands or a finished special result
  typedef struct packed {
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic [31:0] sum;
    logic [7:0]  e;
  } fa_sum_t;

  // stage 2 -> stage 3: sum with leading one position
  typedef struct packed {
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic [31:0] sum;
    logic [7:0]  e;
    logic [4:0]  lead;
  } fa_norm_t;

endpackage

FILE: rtl/core/fa_align.sv
// ----------------------------------------------------------------------------
// fa_align
// decodes operands, handles special cases, aligns and adds significands
// ----------------------------------------------------------------------------
module fa_align import fa_pkg::*; (
  input  logic [31:0] addend_a,
  input  logic [31:0] addend_b,
  output fa_sum_t     res
);

  logic [7:0]  xer, yer, xe, ye, shamt8;
  logic [22:0] xf, yf;
  logic        xs, ys, xnan, ynan, xinf, yinf, x_ge;
  logic [31:0] xsig, ysig, xa, ya;
  logic [4:0]  shamt;

  // field decode
  always_comb begin
    xer  = addend_a[30:23];
    yer  = addend_b[30:23];
    xf   = addend_a[22:0];
    yf   = addend_b[22:0];
    xs   = addend_a[31];
    ys   = addend_b[31];
    xnan = (xer == EXP_MASK) && (xf != '0);
    ynan = (yer == EXP_MASK) && (yf != '0);
    xinf = (xer == EXP_MASK);
    yinf = (yer == EXP_MASK);
    xsig = {1'b0, (xer != '0), xf, 7'b0};
    ysig = {1'b0, (yer != '0), yf, 7'b0};
    xe   = (xer != '0) ? xer : 8'd1;
    ye   = (yer != '0) ? yer : 8'd1;
    x_ge = (xe >= ye);
    shamt8 = x_ge ? (xe - ye) : (ye - xe);
    shamt = (shamt8 > 8'd31) ? 5'd31 : shamt8[4:0];
    xa = x_ge ? xsig : (xsig >> shamt);
    ya = x_ge ? (ysig >> shamt) : ysig;
  end

  // special cases and signed add
  always_comb begin
    res.special      = 1'b1;
    res.special_bits = QNAN_BITS;
    res.sign         = 1'b0;
    res.sum          = '0;
    res.e            = x_ge ? xe : ye;
    if (addend_a == '0) begin
      res.special_bits = addend_b;
    end else if (addend_b == '0) begin
      res.special_bits = addend_a;
    end else if (xnan || ynan) begin
      res.special_bits = QNAN_BITS;
    end else if (xinf) begin
      res.special_bits = (yinf && (xs != ys)) ? QNAN_BITS : addend_a;
    end else if (yinf) begin
      res.special_bits = addend_b;
    end else begin
      res.special = 1'b0;
      if (xs == ys) begin
        res.sum  = xa + ya;
        res.sign = xs;
      end else if (xa > ya) begin
        res.sum  = xa - ya;
        res.sign = xs;
      end else if (xa < ya) begin
        res.sum  = ya - xa;
        res.sign = ys;
      end
    end
  end

endmodule

FILE: rtl/core/fa_lead.sv
// ----------------------------------------------------------------------------
// fa_lead
// finds the leading one of the aligned sum
// ----------------------------------------------------------------------------
module fa_lead import fa_pkg::*; (
  input  fa_sum_t  din,
  output fa_norm_t dout
);

  logic [4:0] lead;

  // priority search, lowest set bit overwritten by higher ones
  always_comb begin
    lead = '0;
    for (int k = 0; k < 32; k++) begin
      if (din.sum[k]) lead = 5'(k);
    end
    dout.special      = din.special;
    dout.special_bits = din.special_bits;
    dout.sign         = din.sign;
    dout.sum          = din.sum;
    dout.e            = din.e;
    dout.lead         = lead;
  end

endmodule

FILE: rtl/core/fa_round.sv
// ----------------------------------------------------------------------------
// fa_round
// normalizes, rounds normal results to nearest even, truncates subnormal ones, packs
// ----------------------------------------------------------------------------
module fa_round import fa_pkg::*; (
  input  fa_norm_t    din,
  output logic [31:0] sum_bits
);

  logic signed [10:0] biased;
  logic [4:0]  d;
  logic [31:0] keep, sub_keep, half_mask;
  logic        rbit, sticky;

  always_comb begin
    biased    = 11'(signed'({3'b0, din.e})) + 11'(signed'({6'b0, din.lead})) - 11'sd30;
    d         = din.lead - 5'd23;
    rbit      = 1'b0;
    sticky    = 1'b0;
    half_mask = '0;
    keep      = '0;
    sum_bits  = '0;
    // subnormal scaling
    if (din.e >= 8'd8) sub_keep = din.sum << (din.e - 8'd8);
    else               sub_keep = din.sum >> (8'd8 - din.e);
    // normalize and round
    if (din.lead >= 5'd24) begin
      rbit      = din.sum[d - 5'd1];
      half_mask = (32'd1 << (d - 5'd1)) - 32'd1;
      sticky    = (din.sum & half_mask) != '0;
      keep      = din.sum >> d;
      if (rbit && (sticky || keep[0])) keep = keep + 32'd1;
      if (keep[31:24] != '0) begin
        keep   = keep >> 1;
        biased = biased + 11'sd1;
      end
    end else begin
      keep = din.sum << (5'd23 - din.lead);
    end
    // pack
    if (din.special) begin
      sum_bits = din.special_bits;
    end else if (din.sum == '0) begin
      sum_bits = {din.sign, 31'b0};
    end else if (biased <= 11'sd0) begin
      sum_bits = {din.sign, 8'b0, sub_keep[22:0] & FRAC_MASK};
    end else if (biased > 11'(signed'({3'b0, EXP_MAX_NORM}))) begin
      sum_bits = {din.sign, EXP_MASK, 23'b0};
    end else begin
      sum_bits = {din.sign, biased[7:0], keep[22:0] & FRAC_MASK};
    end
  end

endmodule

FILE: rtl/core/binary32_float_adder_unit.sv
// ----------------------------------------------------------------------------
// binary32_float_adder_unit
// pipelined binary32 adder with valid/stall handshake
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid, in_stall, addend_a, addend_b; a beat moves when
//   in_valid is high and in_stall low.
//   output channel: out_valid, out_stall, sum_bits; same rule.
//   three register stages: align/add, leading one search, round/pack into
//   the output register. throughput is one beat per cycle while out_stall
//   is low; a full stage holds its contents while the stage after it
//   cannot take a beat, and an empty stage always takes a new one.
//   in_stall is high only when the pipe is full and the output is stalled;
//   bubbles fill in behind a stalled output.
//   reset clears all valid bits; no results are pending after reset.
//   the unit keeps no state between beats.
// ----------------------------------------------------------------------------
`include "binary32_float_adder_unit_defines.svh"
module binary32_float_adder_unit import fa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] addend_a,
  input  logic [31:0] addend_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] sum_bits
);

  fa_sum_t     s1_c, s1;
  fa_norm_t    s2_c, s2;
  logic [31:0] s3_c, s3;
  logic        v1, v2, v3;
  logic        en3, en2, en1;

  fa_align u_align (.addend_a(addend_a), .addend_b(addend_b), .res(s1_c));
  fa_lead  u_lead  (.din(s1), .dout(s2_c));
  fa_round u_round (.din(s2), .sum_bits(s3_c));

  // stage enables, a stage moves when the next one can take it
  assign en3 = !v3 || !out_stall;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_c;
    if (en2) s2 <= s2_c;
    if (en3) s3 <= s3_c;
  end

  assign out_valid = v3;
  assign sum_bits  = s3;

  `FA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sum_bits), "stalled result changed")
  `FA_ASSERT_ALWAYS(a_stall_full, clk, rst, !in_stall || (v1 && v2 && v3 && out_stall), "input stalled without full pipe")
  `FA_ASSERT_NEXT(a_advance, clk, rst, v2 && !(v3 && out_stall), v3, "stage two beat lost")

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression for the binary32 adder: directed special cases, random operand
// pairs in several idle mixes and a hold-off, checked by a local predictor
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] addend_a;
  logic [31:0] addend_b;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] sum_bits;

  logic [31:0] sum_queue[$];
  int          fail_count;
  int          beats_in;
  int          beats_out;
  int          idle_cycles;
  int          in_idle_pct;
  int          out_stall_pct;
  bit          hold_off;
  bit          hold_seen_stall;

  localparam logic [31:0] INF_BITS = 32'h7F80_0000;
  localparam int          WATCHDOG = 20000;

  binary32_float_adder_unit u_dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sum predictor: integer-only binary32 add with truncating alignment
  function automatic logic [31:0] predict_sum(logic [31:0] x, logic [31:0] y);
    logic [7:0]  xe_raw, ye_raw;
    logic [22:0] xf, yf;
    logic        xs, ys, sgn, rbit, sticky;
    logic [31:0] xsig, ysig, s, keep, d;
    int          xe, ye, e, shamt, lead, biased;
    if (x == 32'd0) return y;
    if (y == 32'd0) return x;
    xe_raw = x[30:23];
    ye_raw = y[30:23];
    xf = x[22:0];
    yf = y[22:0];
    xs = x[31];
    ys = y[31];
    if (xe_raw == fa_pkg::EXP_MASK && xf != 0) return fa_pkg::QNAN_BITS;
    if (ye_raw == fa_pkg::EXP_MASK && yf != 0) return fa_pkg::QNAN_BITS;
    if (xe_raw == fa_pkg::EXP_MASK) begin
      if (ye_raw == fa_pkg::EXP_MASK && xs != ys) return fa_pkg::QNAN_BITS;
      return x;
    end
    if (ye_raw == fa_pkg::EXP_MASK) return y;
    xsig = {2'b00, xf, 7'd0} | (xe_raw != 0 ? fa_pkg::IMPLICIT_ONE : 32'd0);
    ysig = {2'b00, yf, 7'd0} | (ye_raw != 0 ? fa_pkg::IMPLICIT_ONE : 32'd0);
    xe = (xe_raw != 0) ? xe_raw : 1;
    ye = (ye_raw != 0) ? ye_raw : 1;
    if (xe >= ye) begin
      shamt = (xe - ye > 31) ? 31 : xe - ye;
      ysig = ysig >> shamt;
      e = xe;
    end else begin
      shamt = (ye - xe > 31) ? 31 : ye - xe;
      xsig = xsig >> shamt;
      e = ye;
    end
    if (xs == ys) begin
      s = xsig + ysig;
      sgn = xs;
    end else if (xsig > ysig) begin
      s = xsig - ysig;
      sgn = xs;
    end else if (xsig < ysig) begin
      s = ysig - xsig;
      sgn = ys;
    end else begin
      s = 0;
      sgn = 1'b0;
    end
    if (s == 0) return {sgn, 31'd0};
    lead = 0;
    for (int k = 31; k >= 0; k--) begin
      if (s[k]) begin
        lead = k;
        break;
      end
    end
    biased = e + lead - 30;
    // below normal range: scale to units of 2^-149, truncating
    if (biased <= 0) begin
      keep = (e >= 8) ? s << (e - 8) : s >> (8 - e);
      return {sgn, 8'd0, keep[22:0]};
    end
    if (lead >= 24) begin
      d = lead - 23;
      rbit = s[d - 1];
      sticky = (s & ((32'd1 << (d - 1)) - 1)) != 0;
      keep = s >> d;
      if (rbit && (sticky || keep[0])) keep = keep + 1;
      if (keep[31:24] != 0) begin
        keep = keep >> 1;
        biased++;
      end
    end else begin
      keep = s << (23 - lead);
    end
    if (biased > fa_pkg::EXP_MAX_NORM) return {sgn, 31'd0} | INF_BITS;
    return {sgn, biased[7:0], keep[22:0]};
  endfunction

  // send one operand pair, with random idle cycles before it
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    addend_a <= a;
    addend_b <= b;
    @(posedge clk);
    while (in_stall) begin
      hold_seen_stall = hold_seen_stall | hold_off;
      @(posedge clk);
    end
    sum_queue.push_back(predict_sum(a, b));
    beats_in++;
  endtask

  // receiver stall, and a long hold-off on request
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < out_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (sum_queue.size() == 0) begin
        $error("sum_bits: unexpected beat, actual %h", sum_bits);
        fail_count++;
      end else begin
        want = sum_queue.pop_front();
        if (sum_bits !== want) begin
          $error("sum_bits: expected %h actual %h", want, sum_bits);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG);
      $display("binary32_float_adder_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'hFE;
      3: v[30:23] = 8'h01;
      4: v = 32'd0;
      5: v[22:0] = $urandom_range(1) ? 23'd0 : 23'h7F_FFFF;
      default: ;
    endcase
    return v;
  endfunction

  // second operand near the first, to hit cancellation and rounding
  function automatic logic [31:0] near_operand(logic [31:0] a);
    logic [31:0] v;
    v = a;
    v[31] = 1'($urandom_range(1));
    v[30:23] = 8'(a[30:23] + $urandom_range(3) - 1);
    v[3:0] = 4'($urandom);
    if ($urandom_range(3) == 0) v[22:0] = 23'($urandom);
    return v;
  endfunction

  task automatic test_directed();
    logic [31:0] ops[$];
    in_idle_pct = 0;
    out_stall_pct = 0;
    ops = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
            32'h7FC0_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
            32'h807F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'hBF80_0000};
    send_pair(32'h0000_0000, 32'h7FC0_0001);   // zero passes a nan through
    send_pair(32'h7F80_0001, 32'h0000_0000);
    send_pair(32'h7F80_0000, 32'hFF80_0000);   // opposite infinities
    send_pair(32'hFF80_0000, 32'hFF80_0000);
    send_pair(32'h3F80_0000, 32'h7F80_0000);
    send_pair(32'h8000_0000, 32'h8000_0000);   // -0 + -0
    send_pair(32'h3F80_0000, 32'hBF80_0000);   // exact cancellation
    send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow
    send_pair(32'h7F7F_FFFF, 32'h7300_0000);   // round up into infinity
    send_pair(32'h0000_0001, 32'h8000_0002);   // subnormal difference
    send_pair(32'h0080_0000, 32'h8000_0001);   // drop below normal range
    send_pair(32'h3F80_0000, 32'h3380_0000);   // tie to even
    send_pair(32'h3F80_0001, 32'h3380_0000);   // tie, odd: rounds up
    send_pair(32'h4B7F_FFFF, 32'h3F00_0000);
    send_pair(32'h7F00_0000, 32'h0000_0001);   // shift capped at 31
    send_pair(32'hFFFF_FFFF, 32'h3F80_0000);
    for (int i = 0; i < 8; i++)
      send_pair(ops[$urandom_range(ops.size() - 1)], ops[$urandom_range(ops.size() - 1)]);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    logic [31:0] a;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      a = rand_operand();
      send_pair(a, ($urandom_range(2) == 0) ? near_operand(a) : rand_operand());
    end
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (40) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_pair($urandom, $urandom);
    join
    if (!hold_seen_stall) begin
      $error("in_stall: expected high during hold-off, actual low");
      fail_count++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    addend_a = '0;
    addend_b = '0;
    fail_count = 0;
    beats_in = 0;
    beats_out = 0;
    hold_off = 1'b0;
    hold_seen_stall = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100, 0, 0);
    test_random(100, 75, 0);
    test_random(100, 0, 75);
    test_random(100, 32, 32);
    test_backpressure();
    in_valid <= 1'b0;
    out_stall_pct = 20;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d operand pairs and %0d sums: specials, rounding, subnormals,",
             beats_in, beats_out);
    $display("overflow, idle and stall mixes, and a long output hold-off");
    if (fail_count == 0) $display("binary32_float_adder_unit regression: pass");
    else $display("binary32_float_adder_unit regression: fail");
    $finish;
  end
endmodule
